/* rtl/qsb_pkg.sv */
// Package for the quicksort buffer sorter.
// Holds sizes, item payload types and the command/status structs passed between the modules.
// No dependencies.
package qsb_pkg;

  localparam int unsigned MAX_ITEMS = 16;
  localparam int unsigned IDX_W     = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int unsigned DATA_W    = 32;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_value;
    logic                     last_item;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflow;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

  typedef enum logic [1:0] {
    WR_IN,
    WR_RD_A,
    WR_RD_B
  } wr_sel_t;

  typedef struct packed {
    logic             wr_en;
    wr_sel_t          wr_sel;
    logic [IDX_W-1:0] wr_addr;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr_a;
    logic [IDX_W-1:0] rd_addr_b;
    logic             pivot_load;
    logic             out_load;
    logic             out_last;
    logic             out_ovf;
  } dp_cmd_t;

  typedef struct packed {
    logic lt;
    logic gt;
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    range_t push_range;
  } stk_cmd_t;

  typedef struct packed {
    range_t top;
    logic   empty;
  } stk_stat_t;

endpackage

/* rtl/quicksort_buffer_sorter.sv */
// Quicksort buffer sorter, top level.
// Depends on qsb_pkg, qsb_ctrl, qsb_datapath and qsb_range_stack.
//
// Usage: send signed 32-bit values on the in_ channel (valid/ready), one per
// item; the item with last_item set closes the set. Up to MAX_ITEMS values are
// buffered; further values are dropped and the final result carries overflow.
// Loading takes one item per cycle. After the last item the block sorts in
// place with a Hoare partition (first element as pivot) driven by a range
// stack, its pace limited by the two-read, one-write element memory. Results
// then leave on the out_ channel one at a time, each read from memory before
// it enters the output register, the last one flagged by last_out. in_ready
// is low from the last item until the final result sits in the output
// register; the next set may load while that result still waits. A stalled
// receiver holds the output register and pauses the emit sequence.
// Synchronous reset returns to loading with an empty buffer and an empty
// output register.
module quicksort_buffer_sorter (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  qsb_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output qsb_pkg::out_item_t  out_item
);
  import qsb_pkg::*;

  dp_cmd_t   dp_cmd;
  dp_stat_t  dp_stat;
  stk_cmd_t  stk_cmd;
  stk_stat_t stk_stat;

  qsb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_item.last_item),
    .in_ready (in_ready),
    .dp_cmd   (dp_cmd),
    .dp_stat  (dp_stat),
    .stk_cmd  (stk_cmd),
    .stk_stat (stk_stat)
  );

  qsb_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .dp_cmd    (dp_cmd),
    .dp_stat   (dp_stat),
    .in_data   (in_item.data_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  qsb_range_stack u_stack (
    .clk      (clk),
    .rst_n    (rst_n),
    .stk_cmd  (stk_cmd),
    .stk_stat (stk_stat)
  );

endmodule

/* rtl/qsb_range_stack.sv */
// Stack of pending index ranges for the partition sequencer.
// Depends on qsb_pkg.
module qsb_range_stack (
  input  logic                clk,
  input  logic                rst_n,
  input  qsb_pkg::stk_cmd_t   stk_cmd,
  output qsb_pkg::stk_stat_t  stk_stat
);
  import qsb_pkg::*;

  range_t           entries_r [MAX_ITEMS];
  logic [CNT_W-1:0] sp_r;
  logic [CNT_W-1:0] sp_nxt;
  logic [CNT_W-1:0] sp_m1;
  logic             do_push;
  logic             do_pop;

  assign sp_m1   = sp_r - CNT_W'(1);
  assign do_push = stk_cmd.push && (sp_r < CNT_W'(MAX_ITEMS));
  assign do_pop  = stk_cmd.pop && (sp_r != '0);

  always_comb begin
    sp_nxt = sp_r;
    if (do_push) begin
      sp_nxt = sp_r + CNT_W'(1);
    end else if (do_pop) begin
      sp_nxt = sp_m1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else begin
      sp_r <= sp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[sp_r[IDX_W-1:0]] <= stk_cmd.push_range;
    end
  end

  assign stk_stat.top   = entries_r[sp_m1[IDX_W-1:0]];
  assign stk_stat.empty = (sp_r == '0);

endmodule

/* rtl/qsb_datapath.sv */
// Datapath: element memory, pivot register, compares and the output register.
// Depends on qsb_pkg.
module qsb_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  qsb_pkg::dp_cmd_t     dp_cmd,
  output qsb_pkg::dp_stat_t    dp_stat,
  input  logic signed [31:0]   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qsb_pkg::out_item_t   out_item
);
  import qsb_pkg::*;

  logic signed [DATA_W-1:0] store_r [MAX_ITEMS];
  logic signed [DATA_W-1:0] rd_a_r;
  logic signed [DATA_W-1:0] rd_b_r;
  logic signed [DATA_W-1:0] pivot_r;
  logic signed [DATA_W-1:0] wr_data;
  out_item_t                out_r;
  logic                     out_valid_r;

  always_comb begin
    case (dp_cmd.wr_sel)
      WR_IN:   wr_data = in_data;
      WR_RD_A: wr_data = rd_a_r;
      WR_RD_B: wr_data = rd_b_r;
      default: wr_data = in_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.wr_en) begin
      store_r[dp_cmd.wr_addr] <= wr_data;
    end
    if (dp_cmd.rd_en) begin
      rd_a_r <= store_r[dp_cmd.rd_addr_a];
      rd_b_r <= store_r[dp_cmd.rd_addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.pivot_load) begin
      pivot_r <= rd_a_r;
    end
    if (dp_cmd.out_load) begin
      out_r.sorted_value <= rd_a_r;
      out_r.last_out     <= dp_cmd.out_last;
      out_r.overflow     <= dp_cmd.out_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign dp_stat.lt       = (rd_a_r < pivot_r);
  assign dp_stat.gt       = (rd_b_r > pivot_r);
  assign dp_stat.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

/* rtl/qsb_ctrl.sv */
// Controller: load, partition sequencing and emit state machine with its index registers.
// Depends on qsb_pkg; drives qsb_datapath and qsb_range_stack.
module qsb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output qsb_pkg::dp_cmd_t    dp_cmd,
  input  qsb_pkg::dp_stat_t   dp_stat,
  output qsb_pkg::stk_cmd_t   stk_cmd,
  input  qsb_pkg::stk_stat_t  stk_stat
);
  import qsb_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_INIT,
    S_POP,
    S_PIVOT,
    S_SCAN,
    S_SWAP_A,
    S_SWAP_B,
    S_FETCH,
    S_PUSH_L,
    S_PUSH_R,
    S_EMIT_RD,
    S_EMIT_PUT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             dropped_r, dropped_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  logic [IDX_W-1:0] sl_r, sl_nxt;
  logic [IDX_W-1:0] sh_r, sh_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic             move_l;
  logic             move_r;
  logic             emit_last;

  assign move_l    = (sl_r < hi_r) && dp_stat.lt;
  assign move_r    = (sh_r > lo_r) && dp_stat.gt;
  assign emit_last = ((CNT_W'(k_r) + CNT_W'(1)) == count_r);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    sl_nxt      = sl_r;
    sh_nxt      = sh_r;
    k_nxt       = k_r;
    in_ready    = 1'b0;
    dp_cmd      = '0;
    dp_cmd.wr_sel = WR_IN;
    stk_cmd     = '0;

    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count_r < CNT_W'(MAX_ITEMS)) begin
            dp_cmd.wr_en   = 1'b1;
            dp_cmd.wr_sel  = WR_IN;
            dp_cmd.wr_addr = count_r[IDX_W-1:0];
            count_nxt      = count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (count_r >= CNT_W'(2)) begin
          stk_cmd.push          = 1'b1;
          stk_cmd.push_range.lo = '0;
          stk_cmd.push_range.hi = IDX_W'(count_r - CNT_W'(1));
        end
        state_nxt = S_POP;
      end
      S_POP: begin
        if (stk_stat.empty) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          stk_cmd.pop      = 1'b1;
          lo_nxt           = stk_stat.top.lo;
          hi_nxt           = stk_stat.top.hi;
          sl_nxt           = stk_stat.top.lo;
          sh_nxt           = stk_stat.top.hi;
          dp_cmd.rd_en     = 1'b1;
          dp_cmd.rd_addr_a = stk_stat.top.lo;
          dp_cmd.rd_addr_b = stk_stat.top.hi;
          state_nxt        = S_PIVOT;
        end
      end
      S_PIVOT: begin
        // pivot is the first element of the range
        dp_cmd.pivot_load = 1'b1;
        dp_cmd.rd_en      = 1'b1;
        dp_cmd.rd_addr_a  = sl_r;
        dp_cmd.rd_addr_b  = sh_r;
        state_nxt         = S_SCAN;
      end
      S_SCAN: begin
        if (move_l || move_r) begin
          // advance both scans together; each stops on its own
          sl_nxt           = move_l ? sl_r + IDX_W'(1) : sl_r;
          sh_nxt           = move_r ? sh_r - IDX_W'(1) : sh_r;
          dp_cmd.rd_en     = 1'b1;
          dp_cmd.rd_addr_a = sl_nxt;
          dp_cmd.rd_addr_b = sh_nxt;
        end else if (sl_r >= sh_r) begin
          state_nxt = S_PUSH_L;
        end else begin
          state_nxt = S_SWAP_A;
        end
      end
      S_SWAP_A: begin
        dp_cmd.wr_en   = 1'b1;
        dp_cmd.wr_sel  = WR_RD_B;
        dp_cmd.wr_addr = sl_r;
        state_nxt      = S_SWAP_B;
      end
      S_SWAP_B: begin
        dp_cmd.wr_en   = 1'b1;
        dp_cmd.wr_sel  = WR_RD_A;
        dp_cmd.wr_addr = sh_r;
        sl_nxt         = sl_r + IDX_W'(1);
        sh_nxt         = sh_r - IDX_W'(1);
        state_nxt      = S_FETCH;
      end
      S_FETCH: begin
        dp_cmd.rd_en     = 1'b1;
        dp_cmd.rd_addr_a = sl_r;
        dp_cmd.rd_addr_b = sh_r;
        state_nxt        = S_SCAN;
      end
      S_PUSH_L: begin
        // left part is lo .. sl-1, kept only if two or more elements
        if ({1'b0, sl_r} >= ({1'b0, lo_r} + (IDX_W+1)'(2))) begin
          stk_cmd.push          = 1'b1;
          stk_cmd.push_range.lo = lo_r;
          stk_cmd.push_range.hi = sl_r - IDX_W'(1);
        end
        state_nxt = S_PUSH_R;
      end
      S_PUSH_R: begin
        if ({1'b0, hi_r} >= ({1'b0, sh_r} + (IDX_W+1)'(2))) begin
          stk_cmd.push          = 1'b1;
          stk_cmd.push_range.lo = sh_r + IDX_W'(1);
          stk_cmd.push_range.hi = hi_r;
        end
        state_nxt = S_POP;
      end
      S_EMIT_RD: begin
        dp_cmd.rd_en     = 1'b1;
        dp_cmd.rd_addr_a = k_r;
        dp_cmd.rd_addr_b = k_r;
        state_nxt        = S_EMIT_PUT;
      end
      S_EMIT_PUT: begin
        if (dp_stat.out_free) begin
          dp_cmd.out_load = 1'b1;
          dp_cmd.out_last = emit_last;
          dp_cmd.out_ovf  = emit_last && dropped_r;
          if (emit_last) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_LOAD;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
      lo_r      <= '0;
      hi_r      <= '0;
      sl_r      <= '0;
      sh_r      <= '0;
      k_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      lo_r      <= lo_nxt;
      hi_r      <= hi_nxt;
      sl_r      <= sl_nxt;
      sh_r      <= sh_nxt;
      k_r       <= k_nxt;
    end
  end

endmodule

/* rtl/qsb_checker.sv */
// Port-level checker for the quicksort buffer sorter, bound to the top level.
// Depends on qsb_pkg and quicksort_buffer_sorter.
module qsb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input qsb_pkg::in_item_t   in_item,
  input logic                out_valid,
  input logic                out_ready,
  input qsb_pkg::out_item_t  out_item
);
  import qsb_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // overflow is reported only on the final result
  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.overflow |-> out_item.last_out)
    else $error("overflow on a non-final result");

  // the closing item starts the sort, so loading stops
  a_last_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_item.last_item |=> !in_ready)
    else $error("input taken right after the closing item");

endmodule

bind quicksort_buffer_sorter qsb_checker u_qsb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);

/* dv/tb_quicksort_buffer_sorter.sv */
// Self-checking testbench for quicksort_buffer_sorter: random and directed sets go in,
// and each sorted item is checked against a local sorting model of the buffer.
// Depends on qsb_pkg and the quicksort_buffer_sorter RTL.
module tb_quicksort_buffer_sorter;
  import qsb_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER = 40;
  localparam int RANDOM_ITEMS = 95;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum int {
    MIX_FULL,
    MIX_DUPS,
    MIX_EXTREMES,
    MIX_RISING,
    MIX_FALLING
  } value_mix_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  in_item_t  pending_items[$];
  out_item_t sorted_expect[$];

  // Buffer model: elements of the set being loaded.
  logic signed [DATA_W-1:0] set_elems[MAX_ITEMS];
  int unsigned set_count = 0;
  logic        set_dropped = 1'b0;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   mismatches = 0;
  int   results_seen = 0;
  int   cycles = 0;

  int in_gap = 0;
  int in_calm = 0;
  int out_gap = 0;
  int out_calm = 0;
  int hold_left = 0;
  logic held = 1'b0;

  quicksort_buffer_sorter dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Store one element; on the closing item, sort the buffer and queue its results.
  task automatic absorb_element(input in_item_t it);
    logic signed [DATA_W-1:0] key;
    out_item_t res;
    int j;
    if (set_count < MAX_ITEMS) begin
      set_elems[set_count] = it.data_value;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (it.last_item) begin
      for (int i = 1; i < set_count; i++) begin
        key = set_elems[i];
        j = i - 1;
        while (j >= 0 && set_elems[j] > key) begin
          set_elems[j + 1] = set_elems[j];
          j--;
        end
        set_elems[j + 1] = key;
      end
      for (int k = 0; k < set_count; k++) begin
        res.sorted_value = set_elems[k];
        res.last_out = (k == set_count - 1);
        res.overflow = (k == set_count - 1) && set_dropped;
        sorted_expect.push_back(res);
      end
      set_count = 0;
      set_dropped = 1'b0;
    end
  endtask

  task automatic queue_item(input logic signed [DATA_W-1:0] v, input logic last);
    in_item_t it;
    it.data_value = v;
    it.last_item = last;
    pending_items.push_back(it);
  endtask

  task automatic queue_set(input int n, input value_mix_t mix);
    logic signed [DATA_W-1:0] v;
    v = $urandom;
    for (int i = 0; i < n; i++) begin
      case (mix)
        MIX_FULL: begin
          v = $urandom;
        end
        MIX_DUPS: begin
          v = $signed($urandom_range(0, 8)) - 4;
        end
        MIX_EXTREMES: begin
          case ($urandom_range(0, 4))
            0: v = VAL_MIN;
            1: v = VAL_MAX;
            2: v = 0;
            3: v = -1;
            default: v = 1;
          endcase
        end
        MIX_RISING: begin
          v = v + $urandom_range(0, 1000);
        end
        default: begin
          v = v - $urandom_range(0, 1000);
        end
      endcase
      queue_item(v, i == n - 1);
    end
  endtask

  // Sender: hold the item until accepted, then pause or offer the next one.
  always @(negedge clk) begin
    in_calm <= (in_calm > 0) ? in_calm - 1 :
               ($urandom_range(0, 99) < 5) ? $urandom_range(30, 60) : 0;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      in_valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_gap <= in_gap - 1;
      in_valid <= 1'b0;
    end else if (pending_items.size() != 0) begin
      in_item <= pending_items.pop_front();
      in_valid <= 1'b1;
      in_gap <= (in_calm > 0) ? 0 : pick_gap();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, plus one long hold-off to back the block up.
  always @(negedge clk) begin
    out_calm <= (out_calm > 0) ? out_calm - 1 :
                ($urandom_range(0, 99) < 5) ? $urandom_range(30, 60) : 0;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!held && results_seen >= HOLD_AFTER) begin
      held <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if (out_fire && out_calm == 0 && $urandom_range(0, 99) < 40) begin
      out_gap <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted input item, check each accepted result.
  always @(posedge clk) begin
    out_item_t exp_item;
    in_fire <= rst_n && in_valid && in_ready;
    out_fire <= rst_n && out_valid && out_ready;
    if (rst_n && in_valid && in_ready) begin
      absorb_element(in_item);
    end
    if (rst_n && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (sorted_expect.size() == 0) begin
        if (mismatches < 10) begin
          $display("unexpected result: value %0d last %0b overflow %0b",
                   out_item.sorted_value, out_item.last_out, out_item.overflow);
        end
        mismatches <= mismatches + 1;
      end else begin
        exp_item = sorted_expect.pop_front();
        if (out_item.sorted_value !== exp_item.sorted_value ||
            out_item.last_out !== exp_item.last_out ||
            out_item.overflow !== exp_item.overflow) begin
          if (mismatches < 10) begin
            $display("mismatch: value %0d/%0d last %0b/%0b overflow %0b/%0b (exp/got)",
                     exp_item.sorted_value, out_item.sorted_value,
                     exp_item.last_out, out_item.last_out,
                     exp_item.overflow, out_item.overflow);
          end
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int queued;
    int n;

    // Single element at the negative extreme.
    queue_item(VAL_MIN, 1'b1);
    // Two extremes in reverse order.
    queue_item(VAL_MAX, 1'b0);
    queue_item(VAL_MIN, 1'b1);
    // Duplicates, zero and minus one.
    queue_item(0, 1'b0);
    queue_item(-1, 1'b0);
    queue_item(VAL_MAX, 1'b0);
    queue_item(-1, 1'b1);
    // Overfill the buffer; the closing item itself is dropped.
    for (int i = 0; i < MAX_ITEMS + 2; i++) begin
      queue_item((i % 2) ? VAL_MAX - i : VAL_MIN + i, i == MAX_ITEMS + 1);
    end

    queued = 0;
    while (queued < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 15) begin
        n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4);
      end else begin
        n = $urandom_range(1, MAX_ITEMS);
      end
      queue_set(n, value_mix_t'($urandom_range(0, 4)));
      queued += n;
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid || sorted_expect.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && sorted_expect.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/qsb_pkg.sv
rtl/qsb_range_stack.sv
rtl/qsb_datapath.sv
rtl/qsb_ctrl.sv
rtl/quicksort_buffer_sorter.sv
rtl/qsb_checker.sv
dv/tb_quicksort_buffer_sorter.sv
